// ----- sv/f2fx_pkg.sv -----
// ----------------------------------------------------------------------------
// f2fx_pkg
// Shared types and constants for the float to fixed-point converter.
// ----------------------------------------------------------------------------
package f2fx_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned FbW   = 7;
	localparam int unsigned ExpW  = 13;  // signed working exponent

	localparam logic [1:0] RM_RNE = 2'd0;
	localparam logic [1:0] RM_RUP = 2'd1;
	localparam logic [1:0] RM_RDN = 2'd2;
	localparam logic [1:0] RM_RTZ = 2'd3;

	// Unpacked operand, stage 1 to stage 2
	typedef struct packed {
		logic              nan;
		logic              big;
		logic              neg;
		logic              is_uns;
		logic              is64;
		logic [1:0]        mode;
		logic [52:0]       sig;
		logic signed [ExpW-1:0] e;
	} unp_t;

	// Shifted magnitude with rounding bits, stage 2 to stage 3
	typedef struct packed {
		logic              nan;
		logic              big;
		logic              neg;
		logic              is_uns;
		logic              is64;
		logic              inc;
		logic              inexact;
		logic [DataW-1:0]  ip;
	} shf_t;

endpackage

// ----- sv/f2fx_unpack.sv -----
// ----------------------------------------------------------------------------
// f2fx_unpack
// Stage 1: splits the IEEE operand and applies the fraction-bit scaling.
// ----------------------------------------------------------------------------
module f2fx_unpack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  logic [63:0]       source_bits,
	input  logic              source_is_single,
	input  logic [6:0]        fraction_bits,
	input  logic              unsigned_result,
	input  logic              result_is_64,
	input  logic [1:0]        round_mode,
	output logic              vld_s1,
	output f2fx_pkg::unp_t    unp_s1
);
	import f2fx_pkg::*;

	unp_t       d;
	logic [10:0] expf;
	logic [52:0] frac;
	logic        emax;

	always_comb begin
		d = '0;
		if (source_is_single) begin
			d.neg = source_bits[31];
			expf  = {3'b0, source_bits[30:23]};
			frac  = {30'b0, source_bits[22:0]};
			emax  = (source_bits[30:23] == 8'hff);
			if (expf == 11'd0) begin
				d.sig = frac;
				d.e   = -ExpW'(149);
			end else begin
				d.sig = frac | 53'h80_0000;
				d.e   = $signed({2'b0, expf}) - ExpW'(150);
			end
		end else begin
			d.neg = source_bits[63];
			expf  = source_bits[62:52];
			frac  = {1'b0, source_bits[51:0]};
			emax  = (expf == 11'h7ff);
			if (expf == 11'd0) begin
				d.sig = frac;
				d.e   = -ExpW'(1074);
			end else begin
				d.sig = frac | {1'b1, 52'b0};
				d.e   = $signed({2'b0, expf}) - ExpW'(1075);
			end
		end
		d.nan    = emax && (frac != 53'd0);
		d.big    = emax && (frac == 53'd0);
		d.e      = d.e + $signed({6'b0, fraction_bits});
		d.is_uns = unsigned_result;
		d.is64   = result_is_64;
		d.mode   = round_mode;
		if (d.nan) d.sig = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (vld_in) unp_s1 <= d;
	end

endmodule

// ----- sv/f2fx_shift.sv -----
// ----------------------------------------------------------------------------
// f2fx_shift
// Stage 2: aligns the significand and works out the rounding increment.
// ----------------------------------------------------------------------------
module f2fx_shift (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s1,
	input  f2fx_pkg::unp_t    unp_s1,
	output logic              vld_s2,
	output f2fx_pkg::shf_t    shf_s2
);
	import f2fx_pkg::*;

	shf_t        d;
	logic [116:0] wide;
	logic [6:0]  sh;
	logic        rnd, sticky;
	logic [63:0] lowmask;
	logic [63:0] sig64;

	always_comb begin
		d         = '0;
		d.nan     = unp_s1.nan;
		d.neg     = unp_s1.neg;
		d.is_uns  = unp_s1.is_uns;
		d.is64    = unp_s1.is64;
		d.big     = unp_s1.big;
		wide      = '0;
		sh        = '0;
		rnd       = 1'b0;
		sticky    = 1'b0;
		lowmask   = '0;
		sig64     = {11'b0, unp_s1.sig};
		if (!unp_s1.big && unp_s1.sig != 53'd0) begin
			if (unp_s1.e >= 64) begin
				d.big = 1'b1;
			end else if (unp_s1.e >= 0) begin
				// left shift; anything reaching bit 64 overflows
				wide = {64'b0, unp_s1.sig} << unp_s1.e[5:0];
				if (wide[116:64] != '0) d.big = 1'b1;
				d.ip = wide[63:0];
			end else if (unp_s1.e < -63) begin
				d.inexact = 1'b1;
				sticky    = 1'b1;
			end else begin
				sh        = 7'(-unp_s1.e);
				d.ip      = 64'({11'b0, unp_s1.sig} >> sh);
				// round bit may sit above the significand, where it reads as zero
				rnd       = sig64[6'(sh - 7'd1)];
				lowmask   = (64'd1 << 6'(sh - 7'd1)) - 64'd1;
				sticky    = ((sig64 & lowmask) != 64'd0);
				d.inexact = rnd | sticky;
			end
			case (unp_s1.mode)
				RM_RNE:  d.inc = rnd && (sticky || d.ip[0]);
				RM_RUP:  d.inc = d.inexact && !unp_s1.neg;
				RM_RDN:  d.inc = d.inexact && unp_s1.neg;
				default: d.inc = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) shf_s2 <= d;
	end

endmodule

// ----- sv/f2fx_sat.sv -----
// ----------------------------------------------------------------------------
// f2fx_sat
// Stage 3: rounds, range-checks and saturates, registers the result.
// ----------------------------------------------------------------------------
module f2fx_sat (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s2,
	input  f2fx_pkg::shf_t    shf_s2,
	output logic              vld_s3,
	output logic [63:0]       res_s3,
	output logic              inv_s3,
	output logic              inx_s3
);
	import f2fx_pkg::*;

	logic [64:0] mag;
	logic [64:0] limit;
	logic        sat;
	logic [63:0] res, lim_out, neg_mag;

	always_comb begin
		mag = {1'b0, shf_s2.ip} + {64'b0, shf_s2.inc};
		if (shf_s2.is_uns) begin
			limit = shf_s2.is64 ? {1'b0, {64{1'b1}}} : 65'h0_ffff_ffff;
			sat = shf_s2.big || (shf_s2.neg && mag != '0) || (!shf_s2.neg && mag > limit);
			lim_out = shf_s2.neg ? 64'd0 : limit[63:0];
		end else begin
			if (shf_s2.neg) limit = shf_s2.is64 ? {2'b01, 63'b0} : 65'h0_8000_0000;
			else            limit = shf_s2.is64 ? {2'b00, {63{1'b1}}} : 65'h0_7fff_ffff;
			sat = shf_s2.big || mag > limit;
			lim_out = limit[63:0];
		end
		neg_mag = 64'd0 - mag[63:0];
		res = shf_s2.neg ? neg_mag : mag[63:0];
		if (!shf_s2.is64) res[63:32] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			if (shf_s2.nan) begin
				res_s3 <= '0;
				inv_s3 <= 1'b1;
				inx_s3 <= 1'b0;
			end else if (sat) begin
				res_s3 <= lim_out;
				inv_s3 <= 1'b1;
				inx_s3 <= 1'b0;
			end else begin
				res_s3 <= res;
				inv_s3 <= 1'b0;
				inx_s3 <= shf_s2.inexact;
			end
		end
	end

endmodule

// ----- sv/float_to_fixed_converter.sv -----
// From start to done an item passes unpack, align and round/saturate, each stage registered.
// Throughput: one item per cycle; busy is never raised.
// Each stage is a single register and the receiver cannot stall, so nothing holds the pipe.
// Reset (arst_n low) clears the stage valid bits; no result is pending after it.
// ----------------------------------------------------------------------------
// float_to_fixed_converter
// IEEE single/double to 32/64-bit fixed point with rounding and saturation.
// ----------------------------------------------------------------------------
module float_to_fixed_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] source_bits,
	input  logic        source_is_single,
	input  logic [6:0]  fraction_bits,
	input  logic        unsigned_result,
	input  logic        result_is_64,
	input  logic [1:0]  round_mode,
	output logic        done,
	output logic [63:0] result_value,
	output logic        invalid_flag,
	output logic        inexact_flag
);
	import f2fx_pkg::*;

	logic vld_s1, vld_s2;
	unp_t unp_s1;
	shf_t shf_s2;

	assign busy = 1'b0;

	f2fx_unpack u_unpack (
		.clk, .arst_n, .vld_in(start), .source_bits, .source_is_single,
		.fraction_bits, .unsigned_result, .result_is_64, .round_mode,
		.vld_s1, .unp_s1
	);

	f2fx_shift u_shift (.clk, .arst_n, .vld_s1, .unp_s1, .vld_s2, .shf_s2);

	f2fx_sat u_sat (
		.clk, .arst_n, .vld_s2, .shf_s2, .vld_s3(done),
		.res_s3(result_value), .inv_s3(invalid_flag), .inx_s3(inexact_flag)
	);

endmodule

// ----- sv/f2fx_checker.sv -----
// ----------------------------------------------------------------------------
// f2fx_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module f2fx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [63:0] result_value,
	input logic        invalid_flag,
	input logic        inexact_flag,
	input logic        result_is_64
);
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done) else $error("item lost");
	a_nodup: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3)) else $error("spurious result");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(invalid_flag && inexact_flag)) else $error("both flags");
	a_zext: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !result_is_64) |-> ##3 (result_value[63:32] == 32'd0))
		else $error("32-bit result not zero-extended");
endmodule

bind float_to_fixed_converter f2fx_checker u_f2fx_checker (
	.clk, .arst_n, .start, .busy, .done, .result_value, .invalid_flag,
	.inexact_flag, .result_is_64
);

// ----- test/float_to_fixed_converter_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float_to_fixed_converter_chk
// Watches the start and done channels of the converter, works out the
// expected fixed-point value and flags for each accepted item, and compares
// every result in order.
// ----------------------------------------------------------------------------
module float_to_fixed_converter_chk
	import f2fx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] source_bits,
	input  logic        source_is_single,
	input  logic [6:0]  fraction_bits,
	input  logic        unsigned_result,
	input  logic        result_is_64,
	input  logic [1:0]  round_mode,
	input  logic        done,
	input  logic [63:0] result_value,
	input  logic        invalid_flag,
	input  logic        inexact_flag,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [63:0] value;
		logic        invalid;
		logic        inexact;
	} fixed_res_t;

	fixed_res_t fixed_q[$];

	function automatic logic [63:0] sat_limit(logic neg, logic uns, logic wide);
		if (uns)
			return neg ? 64'd0 : (wide ? {64{1'b1}} : 64'h0000_0000_ffff_ffff);
		if (wide)
			return neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		return neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
	endfunction

	function automatic fixed_res_t convert(logic [63:0] raw, logic single,
		logic [6:0] fb, logic uns, logic wide, logic [1:0] mode);
		fixed_res_t r;
		logic        neg, big, inexact, inc, rnd, sticky, sat;
		logic [63:0] sig, mag, ip, lim;
		int          e, sh;
		big = 0; inexact = 0; mag = 0;
		if (single) begin
			neg = raw[31];
			sig = {41'd0, raw[22:0]};
			if (raw[30:23] == 8'hff) begin
				if (sig != 0) return '{64'd0, 1'b1, 1'b0};
				big = 1;
			end
			if (raw[30:23] == 0) e = -149;
			else begin
				sig[23] = 1;
				e = int'(raw[30:23]) - 150;
			end
		end else begin
			neg = raw[63];
			sig = {12'd0, raw[51:0]};
			if (raw[62:52] == 11'h7ff) begin
				if (sig != 0) return '{64'd0, 1'b1, 1'b0};
				big = 1;
			end
			if (raw[62:52] == 0) e = -1074;
			else begin
				sig[52] = 1;
				e = int'(raw[62:52]) - 1075;
			end
		end
		if (!big && sig != 0) begin
			e += int'(fb);
			if (e >= 64) big = 1;
			else if (e > 0) begin
				if ((sig >> (64 - e)) != 0) big = 1;
				else mag = sig << e;
			end else if (e == 0) mag = sig;
			else begin
				sh = -e;
				if (sh > 63) begin
					ip = 0; rnd = 0; sticky = 1;
				end else begin
					ip = sig >> sh;
					rnd = sig[sh-1];
					sticky = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
				end
				inexact = rnd | sticky;
				case (mode)
					RM_RNE: inc = rnd && (sticky || ip[0]);
					RM_RUP: inc = inexact && !neg;
					RM_RDN: inc = inexact && neg;
					default: inc = 0;
				endcase
				mag = ip + 64'(inc);
			end
		end
		if (uns) begin
			lim = wide ? {64{1'b1}} : 64'h0000_0000_ffff_ffff;
			sat = big || (neg && mag != 0) || (!neg && mag > lim);
		end else begin
			lim = neg ? (wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000)
				: (wide ? 64'h7fff_ffff_ffff_ffff : 64'h7fff_ffff);
			sat = big || mag > lim;
		end
		if (sat) return '{sat_limit(neg, uns, wide), 1'b1, 1'b0};
		r.value = neg ? (64'd0 - mag) : mag;
		if (!wide) r.value[63:32] = 0;
		r.invalid = 0;
		r.inexact = inexact;
		return r;
	endfunction

	assign pending = fixed_q.size();

	always @(posedge clk or negedge arst_n) begin
		fixed_res_t want;
		if (!arst_n) begin
			errors <= 0;
			fixed_q.delete();
		end else begin
			if (done) begin
				if (fixed_q.size() == 0) begin
					$display("%0t: result with nothing expected: %h %b %b", $time,
						result_value, invalid_flag, inexact_flag);
					errors <= errors + 1;
				end else begin
					want = fixed_q.pop_front();
					if (want.value !== result_value || want.invalid !== invalid_flag
						|| want.inexact !== inexact_flag) begin
						$display("%0t: mismatch expected %h inv %b inx %b, got %h inv %b inx %b",
							$time, want.value, want.invalid, want.inexact,
							result_value, invalid_flag, inexact_flag);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				fixed_q.push_back(convert(source_bits, source_is_single, fraction_bits,
					unsigned_result, result_is_64, round_mode));
		end
	end

endmodule

// ----- test/float_to_fixed_converter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float_to_fixed_converter_tb
// Directed corner values then random floats across all widths, rounding
// modes and fraction counts, with idle phases on the sending side.
// ----------------------------------------------------------------------------
module float_to_fixed_converter_tb;
	import f2fx_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [63:0] source_bits = 0;
	logic        source_is_single = 0;
	logic [6:0]  fraction_bits = 0;
	logic        unsigned_result = 0;
	logic        result_is_64 = 0;
	logic [1:0]  round_mode = RM_RNE;
	logic        done;
	logic [63:0] result_value;
	logic        invalid_flag;
	logic        inexact_flag;
	int          errors, pending;
	int          idle_pct;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	float_to_fixed_converter dut (.*);
	float_to_fixed_converter_chk chk (.*);

	// present one item, hold until accepted; start drops only if the next is idle
	task automatic send_item(logic [63:0] raw, logic single, logic [6:0] fb,
		logic uns, logic wide, logic [1:0] mode);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		source_bits <= raw;
		source_is_single <= single;
		fraction_bits <= fb;
		unsigned_result <= uns;
		result_is_64 <= wide;
		round_mode <= mode;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// random float biased towards exponents that land near the result range
	function automatic logic [63:0] rand_float(logic single, logic [6:0] fb);
		logic [63:0] raw;
		int          ex;
		raw = {$urandom, $urandom};
		case ($urandom_range(9))
			0: ;
			1: raw[62:0] = 0;
			2: if (single) raw[30:23] = 8'hff; else raw[62:52] = 11'h7ff;
			3: if (single) raw[30:23] = 0; else raw[62:52] = 0;
			default: begin
				ex = $urandom_range(70) - 4 - int'(fb);
				if (single) raw[30:23] = 8'(127 + ex);
				else raw[62:52] = 11'(1023 + ex);
			end
		endcase
		if ($urandom_range(3) == 0) raw[30:0] = raw[30:0] & ~31'h00ff_ffff;
		return raw;
	endfunction

	task automatic rand_item;
		logic       single;
		logic [6:0] fb;
		single = 1'($urandom_range(1));
		fb = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64));
		send_item(rand_float(single, fb), single, fb, 1'($urandom_range(1)),
			1'($urandom_range(1)), 2'($urandom_range(3)));
	endtask

	initial begin
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// corners: zeros, NaN, infinities, halves for each mode, limits, top bits
		send_item(64'h0, 0, 0, 0, 1, RM_RNE);
		send_item(64'h8000_0000_0000_0000, 0, 0, 1, 1, RM_RUP);
		send_item(64'h0000_0000_8000_0000, 1, 5, 0, 0, RM_RNE);
		send_item(64'h7ff8_0000_0000_0000, 0, 0, 0, 1, RM_RNE);
		send_item(64'hffff_ffff_7fc0_0001, 1, 0, 0, 0, RM_RTZ);
		send_item(64'h7ff0_0000_0000_0000, 0, 0, 0, 1, RM_RNE);
		send_item(64'hfff0_0000_0000_0000, 0, 0, 0, 0, RM_RNE);
		send_item(64'h0000_0000_ff80_0000, 1, 0, 1, 0, RM_RNE);
		for (int m = 0; m < 4; m++) begin
			send_item(64'h3fe0_0000_0000_0000, 0, 0, 0, 1, m[1:0]);  // 0.5
			send_item(64'hbff8_0000_0000_0000, 0, 0, 0, 0, m[1:0]);  // -1.5
		end
		send_item(64'hbfd0_0000_0000_0000, 0, 0, 1, 1, RM_RDN);  // -0.25 unsigned
		send_item(64'hbfd0_0000_0000_0000, 0, 0, 1, 1, RM_RTZ);
		send_item(64'h41df_ffff_ffc0_0000, 0, 0, 0, 0, RM_RNE);  // 2^31-1
		send_item(64'h41e0_0000_0000_0000, 0, 0, 0, 0, RM_RNE);  // 2^31
		send_item(64'hc1e0_0000_0000_0000, 0, 0, 0, 0, RM_RNE);  // -2^31
		send_item(64'hc3e0_0000_0000_0000, 0, 0, 0, 1, RM_RNE);  // -2^63
		send_item(64'h43f0_0000_0000_0000, 0, 0, 1, 1, RM_RNE);  // 2^64
		send_item(64'h0000_0000_0000_0001, 0, 127, 0, 1, RM_RUP);
		send_item(64'h0000_0000_0000_0001, 1, 64, 1, 1, RM_RNE);
		send_item(64'hffff_ffff_ffff_ffff, 1, 64, 0, 1, RM_RTZ);
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1, 3: idle_pct = 46;
				default: idle_pct = 16;
			endcase
			repeat (160) rand_item();
			if (ph == 3) begin
				start <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("** float_to_fixed_converter: PASSED **");
		else
			$display("** float_to_fixed_converter: FAILED **");
		$finish;
	end

	initial begin
		#200000;
		$display("** float_to_fixed_converter: FAILED **");
		$finish;
	end

endmodule
